// ----- rtl/owm_pkg.sv -----
// Shared types and constants of the one-wire bus master.
package owm_pkg;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [2:0] FUNC_TICK     = 3'd0;
    localparam logic [2:0] FUNC_RESET    = 3'd1;
    localparam logic [2:0] FUNC_WR_BYTE  = 3'd2;
    localparam logic [2:0] FUNC_RD_BYTE  = 3'd3;
    localparam logic [2:0] FUNC_WR_BIT   = 3'd4;
    localparam logic [2:0] FUNC_RD_BIT   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT             = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE      = 3'd7;

    typedef enum logic [2:0] {
        K_TICK,
        K_RESET,
        K_WR_BYTE,
        K_RD_BYTE,
        K_WR_BIT,
        K_RD_BIT,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       level;
    } t_item;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [7:0] presence_wait;
        logic [7:0] presence_timeout;
        logic [9:0] recovery;
        logic [3:0] write_low;
        logic [6:0] slot;
        logic [3:0] read_low;
        logic [5:0] read_sample;
    } t_cfg;

endpackage

// ----- rtl/owm_front.sv -----
// Front end: accepts input beats and classifies them into queue items.
module owm_front
    import owm_pkg::*;
(
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_USER_W-1:0] i_s_tuser,
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    input  t_q_status            i_q_status,
    output logic                 o_push,
    output t_item                o_item
);

    assign o_s_tready = !i_q_status.full;
    assign o_push     = i_s_tvalid && !i_q_status.full;

    always_comb begin
        o_item.data  = i_s_tdata[7:0];
        o_item.level = i_s_tdata[8];
        unique case (i_s_tuser)
            FUNC_TICK:    o_item.kind = K_TICK;
            FUNC_RESET:   o_item.kind = K_RESET;
            FUNC_WR_BYTE: o_item.kind = K_WR_BYTE;
            FUNC_RD_BYTE: o_item.kind = K_RD_BYTE;
            FUNC_WR_BIT:  o_item.kind = K_WR_BIT;
            FUNC_RD_BIT:  o_item.kind = K_RD_BIT;
            default:      o_item.kind = K_NOP;
        endcase
    end

endmodule

// ----- rtl/owm_queue.sv -----
// Short item queue between the front end and the bus engine.
module owm_queue
    import owm_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.valid = (r_count != '0);
    assign o_item         = r_mem[r_rd];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/owm_back.sv -----
// Bus engine: configuration, reset/slot sequencing and the result register.
module owm_back
    import owm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_status             i_q_status,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_POLL,
        PH_RECOVER,
        PH_WRITE,
        PH_READ_BYTE,
        PH_READ_BIT
    } t_phase;

    t_cfg        r_cfg;
    t_phase      r_phase, n_phase;
    logic [9:0]  r_tick, n_tick;
    logic [7:0]  r_timeout, n_timeout;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic        r_presence, n_presence;
    logic        r_drive, n_drive;
    logic        r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    logic [9:0]  tc1;
    logic [6:0]  slot_e, slot_m1, lim_w, lim_r, samp_e;
    logic [9:0]  rst_low_e;
    logic [7:0]  wait_e;
    logic [3:0]  wlow_e, rlow_e;
    logic [5:0]  rsamp_e;
    logic [7:0]  poll_to;
    logic [7:0]  sh;
    logic        v_done, v_rej;
    logic [7:0]  v_rd;

    assign o_pop      = i_q_status.valid && (!r_ovalid || i_m_tready);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    assign slot_e    = (r_cfg.slot < 7'd2) ? 7'd2 : r_cfg.slot;
    assign slot_m1   = slot_e - 7'd1;
    assign rst_low_e = (r_cfg.reset_low == '0) ? 10'd1 : r_cfg.reset_low;
    assign wait_e    = (r_cfg.presence_wait == '0) ? 8'd1 : r_cfg.presence_wait;
    assign wlow_e    = (r_cfg.write_low == '0) ? 4'd1 : r_cfg.write_low;
    assign rlow_e    = (r_cfg.read_low == '0) ? 4'd1 : r_cfg.read_low;
    assign rsamp_e   = (r_cfg.read_sample == '0) ? 6'd1 : r_cfg.read_sample;
    assign lim_w     = (r_shift[0] && ({3'd0, wlow_e} < slot_m1)) ? {3'd0, wlow_e} : slot_m1;
    assign lim_r     = ({3'd0, rlow_e} < slot_m1) ? {3'd0, rlow_e} : slot_m1;
    assign samp_e    = ({1'b0, rsamp_e} < slot_e) ? {1'b0, rsamp_e} : slot_e;
    assign tc1       = r_tick + 10'd1;
    assign poll_to   = (r_phase == PH_RST_WAIT) ? r_cfg.presence_timeout : r_timeout;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_timeout  = r_timeout;
        n_bits     = r_bits;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_drive    = r_drive;
        v_done     = 1'b0;
        v_rej      = 1'b0;
        v_rd       = '0;
        sh         = r_shift;
        if (i_item.kind != K_TICK && i_item.kind != K_NOP) begin
            if (r_phase != PH_IDLE) begin
                v_rej = 1'b1;
            end else begin
                n_tick  = '0;
                n_drive = 1'b1;
                unique case (i_item.kind)
                    K_RESET: begin
                        n_phase    = PH_RST_LOW;
                        n_presence = 1'b0;
                    end
                    K_WR_BYTE: begin
                        n_phase = PH_WRITE;
                        n_shift = i_item.data;
                        n_bits  = 4'd8;
                    end
                    K_RD_BYTE: begin
                        n_phase = PH_READ_BYTE;
                        n_shift = '0;
                        n_bits  = 4'd8;
                    end
                    K_WR_BIT: begin
                        n_phase = PH_WRITE;
                        n_shift = {7'd0, i_item.data[0]};
                        n_bits  = 4'd1;
                    end
                    K_RD_BIT: begin
                        n_phase = PH_READ_BIT;
                        n_shift = '0;
                        n_bits  = 4'd1;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i_item.kind == K_TICK && r_phase != PH_IDLE) begin
            n_tick = tc1;
            unique case (r_phase)
                PH_RST_LOW: begin
                    if (tc1 >= rst_low_e) begin
                        n_drive = 1'b0;
                        n_tick  = '0;
                        n_phase = PH_RST_WAIT;
                    end
                end
                PH_RST_WAIT, PH_POLL: begin
                    if (r_phase == PH_POLL || tc1 >= {2'd0, wait_e}) begin
                        n_tick    = '0;
                        n_phase   = PH_POLL;
                        n_timeout = poll_to;
                        if (!i_item.level) begin
                            n_presence = 1'b1;
                            if (r_cfg.recovery == '0) begin
                                n_phase = PH_IDLE;
                                n_drive = 1'b0;
                                v_done  = 1'b1;
                            end else begin
                                n_phase = PH_RECOVER;
                            end
                        end else if (poll_to == '0) begin
                            n_phase = PH_IDLE;
                            n_drive = 1'b0;
                            v_done  = 1'b1;
                        end else begin
                            n_timeout = poll_to - 8'd1;
                        end
                    end
                end
                PH_RECOVER: begin
                    if (tc1 >= r_cfg.recovery) begin
                        n_phase = PH_IDLE;
                        n_drive = 1'b0;
                        n_tick  = '0;
                        v_done  = 1'b1;
                    end
                end
                PH_WRITE: begin
                    if (tc1 >= {3'd0, slot_e}) begin
                        n_shift = r_shift >> 1;
                        n_bits  = r_bits - 4'd1;
                        n_tick  = '0;
                        if (n_bits == '0) begin
                            n_phase = PH_IDLE;
                            n_drive = 1'b0;
                            v_done  = 1'b1;
                        end else begin
                            n_drive = 1'b1;
                        end
                    end else begin
                        n_drive = (tc1 < {3'd0, lim_w});
                    end
                end
                PH_READ_BYTE, PH_READ_BIT: begin
                    if (tc1 == {3'd0, samp_e}) begin
                        sh = (r_phase == PH_READ_BYTE) ? {i_item.level, r_shift[7:1]}
                                                       : {7'd0, i_item.level};
                    end
                    n_shift = sh;
                    if (tc1 >= {3'd0, slot_e}) begin
                        n_bits = r_bits - 4'd1;
                        n_tick = '0;
                        if (n_bits == '0) begin
                            v_rd    = sh;
                            n_phase = PH_IDLE;
                            n_drive = 1'b0;
                            v_done  = 1'b1;
                        end else begin
                            n_drive = 1'b1;
                        end
                    end else begin
                        n_drive = (tc1 < {3'd0, lim_r});
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_drive = 1'b0;
                    n_tick  = '0;
                end
            endcase
        end
        n_odata = {3'd0, v_rej, v_rd, n_presence, v_done, (n_phase != PH_IDLE), n_drive};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low        <= 10'd480;
            r_cfg.presence_wait    <= 8'd60;
            r_cfg.presence_timeout <= 8'd200;
            r_cfg.recovery         <= 10'd480;
            r_cfg.write_low        <= 4'd10;
            r_cfg.slot             <= 7'd60;
            r_cfg.read_low         <= 4'd1;
            r_cfg.read_sample      <= 6'd15;
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_timeout  <= '0;
            r_bits     <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
            r_drive    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RESET_LOW:        r_cfg.reset_low        <= i_cfg_data[9:0];
                    CFG_PRESENCE_WAIT:    r_cfg.presence_wait    <= i_cfg_data[7:0];
                    CFG_PRESENCE_TIMEOUT: r_cfg.presence_timeout <= i_cfg_data[7:0];
                    CFG_RECOVERY:         r_cfg.recovery         <= i_cfg_data[9:0];
                    CFG_WRITE_LOW:        r_cfg.write_low        <= i_cfg_data[3:0];
                    CFG_SLOT:             r_cfg.slot             <= i_cfg_data[6:0];
                    CFG_READ_LOW:         r_cfg.read_low         <= i_cfg_data[3:0];
                    CFG_READ_SAMPLE:      r_cfg.read_sample      <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            if (o_pop) begin
                r_phase    <= n_phase;
                r_tick     <= n_tick;
                r_timeout  <= n_timeout;
                r_bits     <= n_bits;
                r_shift    <= n_shift;
                r_presence <= n_presence;
                r_drive    <= n_drive;
                r_ovalid   <= 1'b1;
                r_odata    <= n_odata;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/one_wire_bus_master.sv -----
// Top level of the one-wire bus master: front end, item queue and bus engine.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  s        | in        | i_s_tvalid/o_s_tready  | tuser func, tdata data, bus_level
//  m        | out       | o_m_tvalid/i_m_tready  | tdata drive_low..rejected
//  cfg      | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One item per clock sustained while the m side takes results; each input beat yields one
// result beat: the queue writes the item, then the bus engine updates and loads the result register.
// The bus engine handles each beat as it pops it; its phase and tick counter set the pace.
// Synchronous active-low reset empties the queue and restores the register defaults.
// A stalled m side fills the QUEUE_DEPTH-entry queue, after which o_s_tready drops.
module one_wire_bus_master
    import owm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_USER_W-1:0]  i_s_tuser,  // [2:0] func
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // [7:0] data, [8] bus_level
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] read_data, [12] rejected
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_q_status q_status;
    t_item     push_item;
    t_item     pop_item;
    logic      push;
    logic      pop;

    owm_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    owm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (q_status)
    );

    owm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_status (q_status),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ----- rtl/owm_checker.sv -----
// Port-level checks of the one-wire bus master, bound to the top level.
module owm_assertions
    import owm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat present right after reset");

    a_full_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result waiting");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> !o_m_tdata[1])
        else $error("operation finished but still busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[12] |-> o_m_tdata[1] && !o_m_tdata[2])
        else $error("command rejected while idle");

endmodule

bind one_wire_bus_master owm_assertions u_owm_assertions (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- tb/sv/owm_checker.sv -----
`timescale 1ns / 100ps
// Checker of the one-wire bus master: predicts each result beat and compares it.
module owm_checker
    import owm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output logic                  o_engine_busy
);

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_RST_LOW,
        OP_RST_WAIT,
        OP_POLL,
        OP_RECOVER,
        OP_WRITE,
        OP_READ_BYTE,
        OP_READ_BIT
    } t_op_phase;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } t_bus_result;

    t_cfg        regs_now;
    t_op_phase   phase_now;
    logic [9:0]  ticks;
    logic [7:0]  polls_left;
    logic [3:0]  bits_left;
    logic [7:0]  shift_byte;
    logic        presence_seen;
    logic        drive_now;
    logic        op_finished;

    t_bus_result bus_results_due[$];
    int          mismatches = 0;
    int          result_no  = 0;

    assign o_errors = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 100) begin
            $display("[%0t] result %0d: %s is %0h, want %0h", $realtime, result_no, what, got,
                     want);
        end
        mismatches++;
    endtask

    task automatic end_op();
        phase_now   = OP_IDLE;
        drive_now   = 1'b0;
        ticks       = '0;
        op_finished = 1'b1;
    endtask

    task automatic take_poll(input logic level);
        phase_now = OP_POLL;
        if (!level) begin
            presence_seen = 1'b1;
            ticks         = '0;
            if (regs_now.recovery == 0) begin
                end_op();
            end else begin
                phase_now = OP_RECOVER;
            end
        end else if (polls_left == 0) begin
            end_op();
        end else begin
            polls_left = polls_left - 8'd1;
        end
    endtask

    task automatic advance_bus_master(input logic [2:0] func, input logic [7:0] data,
                                      input logic level, output t_bus_result res);
        logic [15:0] slot_len;
        logic [15:0] lim;
        logic [15:0] floor_one;
        logic [7:0]  byte_read;
        logic        refused;
        slot_len    = {9'd0, regs_now.slot};
        if (slot_len < 2) slot_len = 16'd2;
        op_finished = 1'b0;
        refused     = 1'b0;
        byte_read   = '0;
        if (func >= FUNC_RESET && func <= FUNC_RD_BIT) begin
            if (phase_now != OP_IDLE) begin
                refused = 1'b1;
            end else begin
                ticks     = '0;
                drive_now = 1'b1;
                case (func)
                    FUNC_RESET: begin
                        phase_now     = OP_RST_LOW;
                        presence_seen = 1'b0;
                    end
                    FUNC_WR_BYTE: begin
                        phase_now  = OP_WRITE;
                        shift_byte = data;
                        bits_left  = 4'd8;
                    end
                    FUNC_RD_BYTE: begin
                        phase_now  = OP_READ_BYTE;
                        shift_byte = '0;
                        bits_left  = 4'd8;
                    end
                    FUNC_WR_BIT: begin
                        phase_now  = OP_WRITE;
                        shift_byte = {7'b0, data[0]};
                        bits_left  = 4'd1;
                    end
                    default: begin
                        phase_now  = OP_READ_BIT;
                        shift_byte = '0;
                        bits_left  = 4'd1;
                    end
                endcase
            end
        end else if (func == FUNC_TICK && phase_now != OP_IDLE) begin
            ticks = ticks + 10'd1;
            case (phase_now)
                OP_RST_LOW: begin
                    floor_one = (regs_now.reset_low == 0) ? 16'd1
                                                          : {6'd0, regs_now.reset_low};
                    if (ticks >= floor_one) begin
                        drive_now = 1'b0;
                        ticks     = '0;
                        phase_now = OP_RST_WAIT;
                    end
                end
                OP_RST_WAIT: begin
                    floor_one = (regs_now.presence_wait == 0) ? 16'd1
                                                              : {8'd0, regs_now.presence_wait};
                    if (ticks >= floor_one) begin
                        ticks      = '0;
                        polls_left = regs_now.presence_timeout;
                        take_poll(level);
                    end
                end
                OP_POLL: begin
                    ticks = '0;
                    take_poll(level);
                end
                OP_RECOVER: begin
                    if (ticks >= regs_now.recovery) end_op();
                end
                OP_WRITE: begin
                    if (ticks >= slot_len) begin
                        shift_byte = shift_byte >> 1;
                        bits_left  = bits_left - 4'd1;
                        if (bits_left == 0) begin
                            end_op();
                        end else begin
                            ticks     = '0;
                            drive_now = 1'b1;
                        end
                    end else begin
                        lim = slot_len - 16'd1;
                        if (shift_byte[0]) begin
                            floor_one = (regs_now.write_low == 0) ? 16'd1
                                                                  : {12'd0, regs_now.write_low};
                            if (floor_one < lim) lim = floor_one;
                        end
                        drive_now = (ticks < lim);
                    end
                end
                default: begin
                    floor_one = (regs_now.read_sample == 0) ? 16'd1
                                                            : {10'd0, regs_now.read_sample};
                    if (floor_one > slot_len) floor_one = slot_len;
                    if (ticks == floor_one) begin
                        if (phase_now == OP_READ_BYTE) shift_byte = {level, shift_byte[7:1]};
                        else shift_byte = {7'b0, level};
                    end
                    if (ticks >= slot_len) begin
                        bits_left = bits_left - 4'd1;
                        if (bits_left == 0) begin
                            byte_read = shift_byte;
                            end_op();
                        end else begin
                            ticks     = '0;
                            drive_now = 1'b1;
                        end
                    end else begin
                        lim       = slot_len - 16'd1;
                        floor_one = (regs_now.read_low == 0) ? 16'd1
                                                             : {12'd0, regs_now.read_low};
                        if (floor_one < lim) lim = floor_one;
                        drive_now = (ticks < lim);
                    end
                end
            endcase
        end
        res.drive_low = drive_now;
        res.busy      = (phase_now != OP_IDLE);
        res.done      = op_finished;
        res.presence  = presence_seen;
        res.read_data = byte_read;
        res.rejected  = refused;
    endtask

    always @(posedge i_clk) begin : watch
        t_bus_result want;
        t_bus_result got;
        if (!i_rst_n) begin
            regs_now.reset_low        = 10'd480;
            regs_now.presence_wait    = 8'd60;
            regs_now.presence_timeout = 8'd200;
            regs_now.recovery         = 10'd480;
            regs_now.write_low        = 4'd10;
            regs_now.slot             = 7'd60;
            regs_now.read_low         = 4'd1;
            regs_now.read_sample      = 6'd15;
            phase_now     = OP_IDLE;
            ticks         = '0;
            polls_left    = '0;
            bits_left     = '0;
            shift_byte    = '0;
            presence_seen = 1'b0;
            drive_now     = 1'b0;
            bus_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RESET_LOW:        regs_now.reset_low        = i_cfg_data[9:0];
                    CFG_PRESENCE_WAIT:    regs_now.presence_wait    = i_cfg_data[7:0];
                    CFG_PRESENCE_TIMEOUT: regs_now.presence_timeout = i_cfg_data[7:0];
                    CFG_RECOVERY:         regs_now.recovery         = i_cfg_data[9:0];
                    CFG_WRITE_LOW:        regs_now.write_low        = i_cfg_data[3:0];
                    CFG_SLOT:             regs_now.slot             = i_cfg_data[6:0];
                    CFG_READ_LOW:         regs_now.read_low         = i_cfg_data[3:0];
                    default:              regs_now.read_sample      = i_cfg_data[5:0];
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.drive_low = i_m_tdata[0];
                got.busy      = i_m_tdata[1];
                got.done      = i_m_tdata[2];
                got.presence  = i_m_tdata[3];
                got.read_data = i_m_tdata[11:4];
                got.rejected  = i_m_tdata[12];
                if (bus_results_due.size() == 0) begin
                    report_mismatch("beat with nothing pending", int'(i_m_tdata), 0);
                end else begin
                    want = bus_results_due.pop_front();
                    if (got.drive_low !== want.drive_low)
                        report_mismatch("drive_low", int'(got.drive_low),
                                        int'(want.drive_low));
                    if (got.busy !== want.busy)
                        report_mismatch("busy", int'(got.busy), int'(want.busy));
                    if (got.done !== want.done)
                        report_mismatch("done", int'(got.done), int'(want.done));
                    if (got.presence !== want.presence)
                        report_mismatch("presence", int'(got.presence), int'(want.presence));
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", int'(got.read_data),
                                        int'(want.read_data));
                    if (got.rejected !== want.rejected)
                        report_mismatch("rejected", int'(got.rejected), int'(want.rejected));
                end
                result_no++;
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_bus_master(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8], want);
                bus_results_due.push_back(want);
            end
        end
        o_pending     <= bus_results_due.size();
        o_engine_busy <= (phase_now != OP_IDLE);
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the one-wire bus master testbench: clock, reset, stimulus and verdict.
module tb_top
    import owm_pkg::*;
();

    localparam int         CYCLE_LIMIT = 3_000_000;
    localparam int         DONE_BIT    = 2;
    localparam logic [2:0] FUNC_NOP    = K_NOP;
    localparam logic [2:0] FUNC_SPARE  = 3'd7;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          cycles       = 0;
    int          ops_finished = 0;
    int          stall_left   = 0;
    bit          burst        = 1'b0;
    int unsigned cfg_val[8];
    int          errors;
    int          pending;
    logic        engine_busy;

    one_wire_bus_master dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    owm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tuser     (s_tuser),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_engine_busy (engine_busy)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** one_wire_bus_master: FAILED **");
            $finish;
        end
    end

    function automatic int draw_pause();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: stall in stretches, count finished operations
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ((cycles % 4000) < 2500 && $urandom_range(99) < 20) stall_left <= draw_pause();
        end
        if (m_tvalid && m_tready && m_tdata[DONE_BIT]) ops_finished <= ops_finished + 1;
    end

    task automatic send_item(input logic [2:0] func, input logic [7:0] data, input logic level);
        int pause;
        pause = burst ? 0 : draw_pause();
        if (pause != 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, level, data};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // tick until the running operation reports done, with some stray beats
    task automatic finish_op(input int seen, input int low_pct, input int noise_pct);
        logic [2:0] func;
        logic [7:0] data;
        logic       level;
        while (ops_finished == seen) begin
            data  = 8'($urandom);
            level = ($urandom_range(99) >= low_pct);
            if ($urandom_range(99) < noise_pct) func = 3'($urandom_range(FUNC_RESET, FUNC_SPARE));
            else func = FUNC_TICK;
            send_item(func, data, level);
        end
    endtask

    task automatic run_op(input logic [2:0] func, input logic [7:0] data, input int low_pct,
                          input int noise_pct);
        int seen;
        seen  = ops_finished;
        burst = ($urandom_range(3) == 0);
        send_item(func, data, 1'b1);
        finish_op(seen, low_pct, noise_pct);
    endtask

    // hold the sender until every result is back and the engine is idle
    task automatic settle_idle();
        forever begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while (pending != 0);
            if (!engine_busy) break;
            repeat (8) send_item(FUNC_TICK, 8'h00, 1'b1);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config();
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        for (int r = CFG_RESET_LOW; r <= CFG_READ_SAMPLE; r++) begin
            case (r)
                CFG_RESET_LOW, CFG_RECOVERY:              keep = 10'h3FF;
                CFG_PRESENCE_WAIT, CFG_PRESENCE_TIMEOUT:  keep = 10'h0FF;
                CFG_WRITE_LOW, CFG_READ_LOW:              keep = 10'h00F;
                CFG_SLOT:                                 keep = 10'h07F;
                default:                                  keep = 10'h03F;
            endcase
            junk = ($urandom_range(3) == 0) ? (CFG_DATA_W'($urandom) & ~keep) : '0;
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(r);
            cfg_data <= (CFG_DATA_W'(cfg_val[r]) & keep) | junk;
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int seen;
        int low_pct;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults; commands while busy are refused
        seen = ops_finished;
        send_item(FUNC_WR_BIT, 8'hFF, 1'b1);
        send_item(FUNC_RESET, 8'h00, 1'b1);
        send_item(FUNC_NOP, 8'h55, 1'b0);
        send_item(FUNC_SPARE, 8'hAA, 1'b1);
        finish_op(seen, 50, 0);
        settle_idle();

        // zero timings
        foreach (cfg_val[r]) cfg_val[r] = 0;
        load_config();
        send_item(FUNC_NOP, 8'hFF, 1'b1);
        send_item(FUNC_SPARE, 8'h00, 1'b0);
        run_op(FUNC_RESET, 8'h00, 0, 0);
        run_op(FUNC_RESET, 8'h00, 100, 0);
        run_op(FUNC_WR_BYTE, 8'h00, 50, 0);
        run_op(FUNC_WR_BYTE, 8'hFF, 50, 0);
        run_op(FUNC_RD_BYTE, 8'h00, 50, 0);
        run_op(FUNC_RD_BIT, 8'h00, 50, 0);
        settle_idle();

        // sample past the slot end, then inside the low pulse
        cfg_val[CFG_RESET_LOW]        = 3;
        cfg_val[CFG_PRESENCE_WAIT]    = 2;
        cfg_val[CFG_PRESENCE_TIMEOUT] = 3;
        cfg_val[CFG_RECOVERY]         = 5;
        cfg_val[CFG_WRITE_LOW]        = 15;
        cfg_val[CFG_SLOT]             = 4;
        cfg_val[CFG_READ_LOW]         = 15;
        cfg_val[CFG_READ_SAMPLE]      = 63;
        load_config();
        run_op(FUNC_RD_BYTE, 8'h00, 50, 0);
        run_op(FUNC_WR_BYTE, 8'hA5, 50, 0);
        settle_idle();
        cfg_val[CFG_READ_SAMPLE] = 2;
        load_config();
        run_op(FUNC_RD_BYTE, 8'h00, 50, 0);
        run_op(FUNC_RD_BIT, 8'h00, 0, 0);
        settle_idle();

        // random short timings and random operations
        repeat (2) begin
            cfg_val[CFG_RESET_LOW]        = $urandom_range(0, 8);
            cfg_val[CFG_PRESENCE_WAIT]    = $urandom_range(0, 4);
            cfg_val[CFG_PRESENCE_TIMEOUT] = $urandom_range(0, 6);
            cfg_val[CFG_RECOVERY]         = $urandom_range(0, 8);
            cfg_val[CFG_WRITE_LOW]        = $urandom_range(0, 15);
            cfg_val[CFG_SLOT]             = $urandom_range(0, 6);
            cfg_val[CFG_READ_LOW]         = $urandom_range(0, 15);
            cfg_val[CFG_READ_SAMPLE]      = $urandom_range(0, 8);
            load_config();
            repeat (4) begin
                case ($urandom_range(3))
                    0:       low_pct = 0;
                    1:       low_pct = 5;
                    2:       low_pct = 50;
                    default: low_pct = 100;
                endcase
                run_op(3'($urandom_range(FUNC_RESET, FUNC_RD_BIT)), 8'($urandom), low_pct, 4);
            end
            settle_idle();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("** one_wire_bus_master: PASSED **");
        end else begin
            $display("** one_wire_bus_master: FAILED **");
        end
        $finish;
    end

endmodule
